// ===== src/signed_int_to_decimal_ascii_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal formatter
// Clocked checks on clock, disabled while reset is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define SITOA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// condition never true outside reset
`define SITOA_NEVER(lbl, cond, msg) \
   `SITOA_ASSERT(lbl, !(cond), msg)
`else
`define SITOA_ASSERT(lbl, prop, msg)
`define SITOA_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/sitoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants, types and sizing function of the signed decimal formatter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // control of the digit cells for one cycle
   typedef struct packed {
      logic clear;      // load zero into every digit
      logic bin_shift;  // add-3 correction and shift one binary bit in
      logic dig_shift;  // move every digit one cell toward the top
   } cell_ctl_type;

   // decimal digits of 2^(bits-1), the largest magnitude; 1233/4096 ~ log10(2)
   function automatic int num_digits(input int bits);
      return (((bits - 1) * 1233) >> 12) + 1;
   endfunction

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Formats a signed integer as decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports                       | Payload
// req     | in        | req_tvalid/tready/tdata     | value
// rsp     | out       | rsp_tvalid/tready/tdata/tlast | ascii_char, last
//
// For each value, the magnitude is first shifted one bit per cycle into the
// BCD cell chain, then the chain moves one digit per cycle to the top, but
// an output stall holds it while the digits are issued.
// A new value is taken only when the previous text is all issued; the last
// character may still sit in the output register.
// Reset is synchronous, active high, and clears the controller only.
// An output stall holds the controller in the sign or digit state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
   import sitoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,  // [VALUE_BITS-1:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [7:0] ascii_char
   output logic                                rsp_tlast   // last
);

`include "signed_int_to_decimal_ascii_top_assert.svh"

   localparam int NUM_DIGITS = num_digits(VALUE_BITS);
   localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int DIG_BITS   = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_SKIP = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [CNT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_BITS-1:0]   dleft_ff, dleft_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0] value;
   logic                  slot_free;
   logic                  req_xfer;
   logic                  digit_phase;
   cell_ctl_type          ctl;
   logic [3:0]            top_digit;
   logic                  overflow;

   assign value       = req_tdata[VALUE_BITS-1:0];
   assign req_tready  = (state_ff == S_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign slot_free   = !rsp_tvalid_ff || rsp_tready;
   assign digit_phase = (state_ff == S_SKIP) || (state_ff == S_EMIT);

   // digit cells
   sitoa_chain #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .bit_in    (mag_ff[VALUE_BITS-1]),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      bit_cnt_in    = bit_cnt_ff;
      dleft_in      = dleft_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ctl           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               neg_in     = value[VALUE_BITS-1];
               mag_in     = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
               bit_cnt_in = CNT_BITS'(VALUE_BITS);
               dleft_in   = DIG_BITS'(NUM_DIGITS);
               ctl.clear  = 1'b1;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            ctl.bin_shift = 1'b1;
            mag_in        = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in    = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == CNT_BITS'(1)) begin
               state_in = neg_ff ? S_SIGN : S_SKIP;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = CHAR_MINUS;
               rsp_last_in   = 1'b0;
               state_in      = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == 4'd0 && dleft_ff != DIG_BITS'(1)) begin
               ctl.dig_shift = 1'b1;
               dleft_in      = dleft_ff - 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = CHAR_ZERO + {4'd0, top_digit};
               rsp_last_in   = (dleft_ff == DIG_BITS'(1));
               ctl.dig_shift = 1'b1;
               dleft_in      = dleft_ff - 1'b1;
               if (dleft_ff == DIG_BITS'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      dleft_ff    <= dleft_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `SITOA_ASSERT(a_accept_conv, req_xfer |=> state_ff == S_CONV, "accept did not start conversion")
   `SITOA_NEVER(a_no_overflow, state_ff == S_CONV && overflow, "digit chain overflow")
   `SITOA_NEVER(a_top_bcd, digit_phase && top_digit > 4'd9, "top digit not BCD")
   `SITOA_NEVER(a_dleft_live, digit_phase && dleft_ff == '0, "no digit left to issue")

endmodule

// ===== src/sitoa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_cell
// One BCD digit of the double-dabble chain.
// ----------------------------------------------------------------------------
module sitoa_cell
   import sitoa_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         bit_in,     // binary bit from the lower cell
   input  logic [3:0]   dig_in,     // digit from the lower cell
   output logic         bit_out,    // binary bit to the upper cell
   output logic [3:0]   dig_out     // digit held by this cell
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   // add 3 when the digit would reach ten after the shift
   assign adj     = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign bit_out = adj[3];
   assign dig_out = digit_ff;

   // next digit
   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = 4'd0;
      end else if (ctl.bin_shift) begin
         digit_in = {adj[2:0], bit_in};
      end else if (ctl.dig_shift) begin
         digit_in = dig_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== src/sitoa_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_chain
// Row of BCD cells; binary bits enter at the bottom, digits leave at the top.
// ----------------------------------------------------------------------------
module sitoa_chain
   import sitoa_pkg::*;
#(
   parameter int NUM_DIGITS = num_digits(VALUE_BITS_DEFAULT)
) (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         bit_in,     // next magnitude bit, MSB first
   output logic [3:0]   top_digit,  // most significant digit
   output logic         overflow    // carry out of the top cell
);

   logic [NUM_DIGITS:0] carry;
   logic [3:0]          dig [NUM_DIGITS+1];

   assign carry[0] = bit_in;
   assign dig[0]   = 4'd0;

   // cell i feeds cell i+1
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      sitoa_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .bit_in  (carry[i]),
         .dig_in  (dig[i]),
         .bit_out (carry[i+1]),
         .dig_out (dig[i+1])
      );
   end

   assign top_digit = dig[NUM_DIGITS];
   assign overflow  = carry[NUM_DIGITS];

endmodule
